>>> rtl/ipv4dq_pkg.sv
// types, constants and helpers shared by the dotted-quad address parser
package ipv4dq_pkg;

  localparam logic [3:0] NAME_LEN   = 4'd9;
  localparam logic [8:0] OCTET_MAX  = 9'd255;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [1:0] DOTS_FULL  = 2'd3;
  localparam logic [1:0] DIGITS_MAX = 2'd3;

  typedef enum logic [1:0] {
    STATUS_VALID     = 2'd0,
    STATUS_LOCALHOST = 2'd1,
    STATUS_INVALID   = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] address;
  } result_t;

  typedef struct packed {
    logic [1:0]  dot_count;
    logic [1:0]  digit_count;
    logic [8:0]  octet_accum;
    logic        leading_zero;
    logic [23:0] packed_octets;
    logic        error_seen;
    logic        name_match;
    logic [3:0]  char_index;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    dot_count:     2'd0,
    digit_count:   2'd0,
    octet_accum:   9'd0,
    leading_zero:  1'b0,
    packed_octets: 24'd0,
    error_seen:    1'b0,
    name_match:    1'b1,
    char_index:    4'd0
  };

  // characters of the name "localhost"
  function automatic logic [7:0] host_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h6c;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h63;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h6c;
      4'd5:    c = 8'h68;
      4'd6:    c = 8'h6f;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/ipv4dq_step.sv
// next-state and result logic for one character of the address text
module ipv4dq_step import ipv4dq_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   character,
  output parse_state_t st_next,
  output result_t      res
);

  logic [3:0]  digit;
  logic [11:0] sum;
  logic        lz_next;
  logic        lz_error;

  assign digit = 4'(character - CHAR_ZERO);
  assign sum   = 12'(st.octet_accum) * 12'd10 + 12'(digit);

  always_comb begin
    st_next  = st;
    lz_next  = 1'b0;
    lz_error = 1'b0;

    // name comparison runs on even after the address has failed
    if (st.char_index < NAME_LEN) begin
      if (character != host_char(st.char_index)) begin
        st_next.name_match = 1'b0;
      end
      st_next.char_index = st.char_index + 4'd1;
    end

    if (!st.error_seen) begin
      if (character == CHAR_DOT) begin
        if (st.digit_count == 2'd0 || st.dot_count == DOTS_FULL) begin
          st_next.error_seen = 1'b1;
        end else begin
          st_next.dot_count     = st.dot_count + 2'd1;
          st_next.packed_octets = {st.packed_octets[15:0], st.octet_accum[7:0]};
          st_next.digit_count   = 2'd0;
          st_next.octet_accum   = 9'd0;
          st_next.leading_zero  = 1'b0;
        end
      end else if (!(character inside {[CHAR_ZERO:CHAR_NINE]})) begin
        st_next.error_seen = 1'b1;
      end else begin
        if (st.digit_count == 2'd0 && character == CHAR_ZERO) begin
          lz_next = 1'b1;
        end else if (st.digit_count == 2'd1 && st.leading_zero) begin
          lz_error = 1'b1;
        end

        if (lz_error || sum > 12'(OCTET_MAX)) begin
          st_next.error_seen = 1'b1;
        end else begin
          st_next.leading_zero = lz_next;
          st_next.octet_accum  = sum[8:0];
          if (st.digit_count < DIGITS_MAX) begin
            st_next.digit_count = st.digit_count + 2'd1;
          end
        end
      end
    end
  end

  always_comb begin
    res.address = 32'd0;
    if (st_next.name_match) begin
      res.status = STATUS_LOCALHOST;
    end else if (st_next.error_seen || st_next.dot_count != DOTS_FULL ||
                 st_next.digit_count == 2'd0) begin
      res.status = STATUS_INVALID;
    end else begin
      res.status  = STATUS_VALID;
      res.address = {st_next.packed_octets, st_next.octet_accum[7:0]};
    end
  end

endmodule

>>> rtl/ipv4_dotted_quad_parser.sv
// dotted-quad ipv4 address parser, one character per request
//
//   channel  | signals                                 | carries
//   ---------+-----------------------------------------+------------------------------
//   char     | char_valid, char_stall, char_data       | character, last flag
//   result   | result_valid, result_stall, result_data | status, packed 32-bit address
//
// one character per cycle while no result is held; a result is registered once the last
// character is taken (input register, then the parse logic into the result register)
// reset puts the parse state at its idle value and empties both registers
// a held result stalls the input register and the parse state together
module ipv4_dotted_quad_parser import ipv4dq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  output logic      char_stall,
  input  char_req_t char_data,
  output logic      result_valid,
  input  logic      result_stall,
  output result_t   result_data
);

  logic         hold;
  logic         in_valid;
  char_req_t    in_req;
  logic         fire;
  parse_state_t state;
  parse_state_t state_next;
  result_t      res;

  assign hold       = result_valid && result_stall;
  assign char_stall = hold;
  assign fire       = in_valid && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!hold) begin
      in_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && char_valid) begin
      in_req <= char_data;
    end
  end

  ipv4dq_step u_step (
    .st        (state),
    .character (in_req.character),
    .st_next   (state_next),
    .res       (res)
  );

  // the final character of a string returns the parser to idle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (fire) begin
      state <= in_req.last ? PARSE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!hold) begin
      result_valid <= in_valid && in_req.last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_req.last) begin
      result_data <= res;
    end
  end

endmodule

>>> rtl/ipv4dq_checker.sv
// port-level checks for the address parser, bound to the top level
module ipv4dq_checker import ipv4dq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      char_stall,
  input logic      result_valid,
  input logic      result_stall,
  input result_t   result_data
);

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(result_data))
    else $error("stalled result changed");

  // address is only meaningful for a valid dotted quad
  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.status != STATUS_VALID |-> result_data.address == 32'd0)
    else $error("address nonzero on non-valid status");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    char_stall |-> result_valid && result_stall)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind ipv4_dotted_quad_parser ipv4dq_checker u_checker (.*);

>>> dv/ipv4_dotted_quad_checker.sv
`timescale 1ns / 100ps
// checker for the dotted-quad parser: predicts each result and compares it
module ipv4_dotted_quad_checker import ipv4dq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      char_valid,
  input  logic      char_stall,
  input  char_req_t char_data,
  input  logic      result_valid,
  input  logic      result_stall,
  input  result_t   result_data,
  output int        fail_count,
  output int        pending
);

  localparam logic [71:0] HOST_TEXT = "localhost";

  // predicted parse state
  logic [1:0]  dots;
  logic [1:0]  digits;
  logic [8:0]  accum;
  logic        zero_lead;
  logic [23:0] earlier_octets;
  logic        addr_bad;
  logic        host_like;
  logic [3:0]  name_pos;

  result_t results_due[$];

  function automatic void clear_parse();
    dots           = '0;
    digits         = '0;
    accum          = '0;
    zero_lead      = 1'b0;
    earlier_octets = '0;
    addr_bad       = 1'b0;
    host_like      = 1'b1;
    name_pos       = '0;
  endfunction

  function automatic void parse_char(input logic [7:0] c);
    logic [12:0] sum;
    if (name_pos < NAME_LEN) begin
      if (c != HOST_TEXT[71 - 8 * name_pos -: 8]) host_like = 1'b0;
      name_pos = name_pos + 4'd1;
    end
    // once the address is bad only the name compare keeps going
    if (addr_bad) return;
    if (c == CHAR_DOT) begin
      if (digits == 2'd0 || dots == DOTS_FULL) begin
        addr_bad = 1'b1;
        return;
      end
      dots           = dots + 2'd1;
      earlier_octets = {earlier_octets[15:0], accum[7:0]};
      digits         = '0;
      accum          = '0;
      zero_lead      = 1'b0;
      return;
    end
    if (c < CHAR_ZERO || c > CHAR_NINE) begin
      addr_bad = 1'b1;
      return;
    end
    if (digits == 2'd0 && c == CHAR_ZERO) begin
      zero_lead = 1'b1;
    end else if (digits == 2'd1 && zero_lead) begin
      addr_bad = 1'b1;
      return;
    end else begin
      zero_lead = 1'b0;
    end
    sum = 13'(accum) * 13'd10 + 13'(c - CHAR_ZERO);
    if (sum > 13'(OCTET_MAX)) begin
      addr_bad = 1'b1;
      return;
    end
    accum = sum[8:0];
    if (digits < DIGITS_MAX) digits = digits + 2'd1;
  endfunction

  function automatic result_t close_string();
    result_t r;
    r.address = '0;
    if (host_like) begin
      r.status = STATUS_LOCALHOST;
    end else if (addr_bad || dots != DOTS_FULL || digits == 2'd0) begin
      r.status = STATUS_INVALID;
    end else begin
      r.status  = STATUS_VALID;
      r.address = {earlier_octets, accum[7:0]};
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      clear_parse();
      results_due.delete();
      fail_count = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing due (status %0d address %h)",
                                    result_data.status, result_data.address));
        end else begin
          want = results_due.pop_front();
          if (result_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      result_data.status, want.status));
          if (result_data.address !== want.address)
            report_mismatch($sformatf("address got %h want %h",
                                      result_data.address, want.address));
        end
      end
      if (char_valid && !char_stall) begin
        parse_char(char_data.character);
        if (char_data.last) begin
          results_due.push_back(close_string());
          clear_parse();
        end
      end
    end
    pending <= results_due.size();
  end

endmodule

>>> dv/ipv4_dotted_quad_parser_test.sv
`timescale 1ns / 100ps
// testbench top for the dotted-quad parser: address strings in, verdict out
module ipv4_dotted_quad_parser_test;
  import ipv4dq_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int GAP_MAX      = 19;
  localparam int IDLE_LIMIT   = 1000;
  localparam int CHAR_TARGET  = 700;
  localparam int DRAIN_CYCLES = 8;

  logic      clk          = 1'b0;
  logic      rst          = 1'b1;
  logic      char_valid   = 1'b0;
  logic      char_stall;
  char_req_t char_data    = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  result_t   result_data;

  int         fail_count;
  int         pending;
  int         idle_cycles = 0;
  int         hold_left   = 0;
  int         sent        = 0;
  bit         calm        = 1'b0;
  bit         sink_calm   = 1'b0;
  logic [7:0] text[$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ipv4_dotted_quad_parser i_dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

  ipv4_dotted_quad_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .char_data    (char_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // one request per character; returns at the edge that takes it
  task automatic send_char(input logic [7:0] c, input logic fin);
    int gap;
    gap = calm ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_data  <= '{character: c, last: fin};
    char_valid <= 1'b1;
    do @(posedge clk); while (char_stall);
    sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
  endtask

  task automatic send_string(input string s);
    text = {};
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text();
  endtask

  // result side: after each result, stall for a drawn number of cycles
  always @(posedge clk) begin : result_sink
    int hold;
    if (rst) begin
      result_stall <= 1'b0;
      hold_left    <= 0;
    end else if (result_valid && !result_stall) begin
      if ($urandom_range(0, 7) == 0) sink_calm = !sink_calm;
      hold = sink_calm ? 0 : $urandom_range(0, GAP_MAX);
      hold_left    <= hold;
      result_stall <= (hold != 0);
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= (hold_left > 1);
    end
  end

  always @(posedge clk) begin
    if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT - 1) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int    pick;
    int    segs;
    int    n;
    int    d;
    string word;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed strings
    send_string("0.255.9.1");
    send_string("localhost");
    send_string("loc");
    text = {8'h00};
    send_text();
    text = {8'hff};
    send_text();
    send_string("01");
    send_string("256");
    send_string(".");
    send_string("9");
    send_string("1.2.3.4.");

    while (sent < CHAR_TARGET) begin
      calm = ($urandom_range(0, 4) == 0);
      text = {};
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        // dotted quad, sometimes with a bad segment or a wrong segment count
        segs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 4;
        for (int i = 0; i < segs; i++) begin
          if (i != 0) text.push_back(CHAR_DOT);
          case ($urandom_range(0, 29))
            0:       word = "";
            1:       word = $sformatf("%0d", $urandom_range(256, 999));
            2:       word = $sformatf("0%0d", $urandom_range(0, 99));
            3:       word = "0";
            4:       word = "255";
            default: word = $sformatf("%0d", $urandom_range(0, 255));
          endcase
          for (int k = 0; k < word.len(); k++) text.push_back(word[k]);
        end
        if (text.size() != 0 && $urandom_range(0, 5) == 0)
          text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (pick < 15) begin
        // prefix of the host name, maybe spoiled, maybe with a tail
        word = "localhost";
        n = $urandom_range(1, 9);
        for (int k = 0; k < n; k++) text.push_back(word[k]);
        if ($urandom_range(0, 3) == 0) text[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
          repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(0, 255)));
      end else begin
        // noise, half of it digits and dots
        repeat ($urandom_range(1, 12)) begin
          d = $urandom_range(0, 10);
          if ($urandom_range(0, 1) == 0) text.push_back(8'($urandom_range(0, 255)));
          else if (d == 10) text.push_back(CHAR_DOT);
          else text.push_back(CHAR_ZERO + 8'(d));
        end
      end
      if (text.size() == 0) text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      send_text();
    end
    char_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
